>>> design/mpct_pkg.sv
// shared types and constants for the mouse packet cursor tracker
// no dependencies; imported by every module of the block
package mpct_pkg;

   localparam int BYTE_W     = 8;
   localparam int BUTTON_W   = 3;
   localparam int CFG_W      = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int SYNC_BIT   = 3;
   localparam int DELTA_W    = BYTE_W + 1;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(80);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(25);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1
   } csr_index_type;

   // packet assembly status seen by the datapath
   typedef struct packed {
      logic              completes;
      logic [BYTE_W-1:0] header;
      logic [BYTE_W-1:0] delta_x;
   } pkt_type;

endpackage

>>> design/mpct_assembler.sv
// groups mouse bytes into three-byte packets with header alignment
// depends on mpct_pkg
module mpct_assembler (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       take,
   input  logic [mpct_pkg::BYTE_W-1:0] data_byte,
   output mpct_pkg::pkt_type          pkt
);
   import mpct_pkg::*;

   typedef enum logic [1:0] {
      POS_HEADER,
      POS_DELTA_X,
      POS_DELTA_Y
   } pos_type;

   pos_type           pos_ff;
   logic [BYTE_W-1:0] header_ff;
   logic [BYTE_W-1:0] delta_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= POS_HEADER;
         header_ff  <= '0;
         delta_x_ff <= '0;
      end else if (take) begin
         case (pos_ff)
            POS_DELTA_X: begin
               delta_x_ff <= data_byte;
               pos_ff     <= POS_DELTA_Y;
            end
            POS_DELTA_Y: begin
               pos_ff <= POS_HEADER;
            end
            default: begin
               // a header without the sync bit is dropped
               if (data_byte[SYNC_BIT]) begin
                  header_ff <= data_byte;
                  pos_ff    <= POS_DELTA_X;
               end
            end
         endcase
      end
   end

   assign pkt.completes = (pos_ff == POS_DELTA_Y);
   assign pkt.header    = header_ff;
   assign pkt.delta_x   = delta_x_ff;

endmodule

>>> design/mpct_axis.sv
// one cursor coordinate: signed step, then saturation to 0 .. size-1
// depends on mpct_pkg
module mpct_axis #(
   parameter int COORD_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              update,
   input  logic signed [mpct_pkg::DELTA_W-1:0] delta,
   input  logic [mpct_pkg::CFG_W-1:0]         size,
   output logic [COORD_BITS-1:0]              pos,
   output logic [COORD_BITS-1:0]              pos_next
);
   import mpct_pkg::*;

   localparam int SUM_W = COORD_BITS + 10;

   logic [COORD_BITS-1:0]   pos_ff;
   logic [COORD_BITS-1:0]   pos_in;
   logic signed [SUM_W-1:0] sum;
   logic [SUM_W-1:0]        size_ext;
   logic [SUM_W-1:0]        cap;
   logic [SUM_W-1:0]        lim;

   always_comb begin
      size_ext = SUM_W'(size);
      cap      = SUM_W'(1) << COORD_BITS;
      // zero size behaves as one, oversize caps at the coordinate range
      if (size_ext == '0) begin
         lim = SUM_W'(1);
      end else if (size_ext > cap) begin
         lim = cap;
      end else begin
         lim = size_ext;
      end
      sum = $signed({{(SUM_W-COORD_BITS){1'b0}}, pos_ff})
          + $signed({{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta});
      if (sum[SUM_W-1]) begin
         pos_in = '0;
      end else if ($unsigned(sum) >= lim) begin
         pos_in = COORD_BITS'(lim - SUM_W'(1));
      end else begin
         pos_in = sum[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (update) begin
         pos_ff <= pos_in;
      end
   end

   assign pos      = pos_ff;
   assign pos_next = pos_in;

endmodule

>>> design/mouse_packet_cursor_tracker.sv
// a byte that completes a packet passes the input register, then the result register
// one byte per cycle unless stalled, set by the input register feeding the result register
// a waiting result stalls only bytes that would complete a further packet
// reset (synchronous, active high) clears the cursor, the packet position and both
// valid flags, and sets the screen size to 80 by 25
module mouse_packet_cursor_tracker #(
   parameter int COORD_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [mpct_pkg::BYTE_W-1:0]     req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [COORD_BITS-1:0]           rsp_cursor_x,
   output logic [COORD_BITS-1:0]           rsp_cursor_y,
   output logic [mpct_pkg::BUTTON_W-1:0]   rsp_button_bits,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mpct_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mpct_pkg::CFG_W-1:0]      csr_write_data
);
   import mpct_pkg::*;

   logic [CFG_W-1:0]         width_ff;
   logic [CFG_W-1:0]         height_ff;
   logic                     in_valid_ff;
   logic [BYTE_W-1:0]        in_byte_ff;
   logic                     rsp_valid_ff;
   logic [COORD_BITS-1:0]    rsp_x_ff;
   logic [COORD_BITS-1:0]    rsp_y_ff;
   logic [BUTTON_W-1:0]      rsp_buttons_ff;
   pkt_type                  pkt;
   logic                     advance;
   logic                     rsp_load;
   logic signed [DELTA_W-1:0] dx;
   logic signed [DELTA_W-1:0] dy;
   logic [COORD_BITS-1:0]    col_pos;
   logic [COORD_BITS-1:0]    col_next;
   logic [COORD_BITS-1:0]    row_pos;
   logic [COORD_BITS-1:0]    row_next;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_write_data;
            CSR_SCREEN_HEIGHT: height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // the held byte moves on unless it completes a packet and the result slot is full and not taken
   assign advance   = in_valid_ff && (!pkt.completes || !rsp_valid_ff || rsp_ready);
   assign rsp_load  = advance && pkt.completes;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
      end
   end

   mpct_assembler u_assembler (
      .clock     (clock),
      .reset     (reset),
      .take      (advance),
      .data_byte (in_byte_ff),
      .pkt       (pkt)
   );

   // row moves opposite to the mouse y delta
   assign dx = $signed({pkt.delta_x[BYTE_W-1], pkt.delta_x});
   assign dy = -$signed({in_byte_ff[BYTE_W-1], in_byte_ff});

   mpct_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
      .clock    (clock),
      .reset    (reset),
      .update   (rsp_load),
      .delta    (dx),
      .size     (width_ff),
      .pos      (col_pos),
      .pos_next (col_next)
   );

   mpct_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
      .clock    (clock),
      .reset    (reset),
      .update   (rsp_load),
      .delta    (dy),
      .size     (height_ff),
      .pos      (row_pos),
      .pos_next (row_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_x_ff       <= col_next;
         rsp_y_ff       <= row_next;
         rsp_buttons_ff <= pkt.header[BUTTON_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cursor_x    = rsp_x_ff;
   assign rsp_cursor_y    = rsp_y_ff;
   assign rsp_button_bits = rsp_buttons_ff;

   // a stalled byte stays in the input register
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input byte lost while stalled");

   // a new result only follows a completed packet
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff) |-> $past(in_valid_ff && pkt.completes))
      else $error("result without completed packet");

   // a pending result matches the stored cursor
   a_result_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_x_ff == col_pos) && (rsp_y_ff == row_pos))
      else $error("result differs from cursor state");

endmodule
